// ----- hdl/drt_pkg.sv -----
// Device registry table: shared constants, opcode and status codes, item types.
// No dependencies; compiled first.
`default_nettype none

package drt_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_TYPE_BITS   = 4;
  localparam int MAX_RESULTS     = 16;
  localparam int INST_MAX        = 15;
  localparam int COUNT_MAX       = 31;

  localparam logic [2:0] OP_ADD       = 3'd0;
  localparam logic [2:0] OP_REMOVE    = 3'd1;
  localparam logic [2:0] OP_FIND_BE   = 3'd2;
  localparam logic [2:0] OP_FIND_INST = 3'd3;
  localparam logic [2:0] OP_COUNT     = 3'd4;
  localparam logic [2:0] OP_LIST      = 3'd5;
  localparam logic [2:0] OP_CLEAR     = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [3:0]         device_type;
    logic signed [31:0] backend_id;
    logic [3:0]         instance_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         entry_index;
    logic [3:0]         entry_type;
    logic signed [31:0] entry_backend_id;
    logic [3:0]         entry_instance;
    logic               entry_connected;
    logic [4:0]         type_count;
    logic               last_result;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/drt_cell.sv -----
// One table slot of the device registry chain. Holds the slot and passes the
// query token to the next cell each cycle. Uses drt_pkg; types come from the top.
`default_nettype none

module drt_cell #(
  parameter int  IDX_W    = 4,
  parameter int  CNT_W    = 5,
  parameter int  CELL_IDX = 0,
  parameter type tok_t,
  parameter type rec_t,
  parameter type wr_t,
  parameter type emit_t
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire tok_t  tok_i,
  output tok_t       tok_o,
  input  wire wr_t   wr_i,
  output emit_t      emit_o
);
  import drt_pkg::*;

  logic        valid_r;
  logic [$bits(tok_i.dtype)-1:0] type_r;
  logic [31:0] backend_r;
  logic [3:0]  inst_r;
  logic        conn_r;
  logic        conn_nxt;
  tok_t        tok_r;
  tok_t        tok_nxt;
  rec_t        own;
  logic        tm;
  logic        bm;
  logic        im;

  assign tok_o = tok_r;

  always_comb begin
    tok_nxt  = tok_i;
    conn_nxt = conn_r;
    emit_o   = '0;
    tm = tok_i.valid && valid_r && (type_r == tok_i.dtype);
    bm = tm && (backend_r == tok_i.backend);
    im = tm && (inst_r == tok_i.inst);
    own         = '0;
    own.idx     = IDX_W'(CELL_IDX);
    own.dtype   = type_r;
    own.backend = backend_r;
    own.inst    = inst_r;
    own.conn    = conn_r;
    case (tok_i.op)
      OP_ADD: begin
        if (bm && !tok_i.hit) begin
          conn_nxt     = 1'b1;
          tok_nxt.hit  = 1'b1;
          tok_nxt.rec  = own;
          tok_nxt.rec.conn = 1'b1;
        end
        // next instance: one past the largest held for this type
        if (tm && ({1'b0, inst_r} >= tok_i.next_inst)) begin
          tok_nxt.next_inst = {1'b0, inst_r} + 5'd1;
        end
      end
      OP_REMOVE: begin
        if (bm && !tok_i.hit) begin
          conn_nxt     = 1'b0;
          tok_nxt.hit  = 1'b1;
          tok_nxt.rec  = own;
          tok_nxt.rec.conn = 1'b0;
        end
      end
      OP_FIND_BE: begin
        if (bm && !tok_i.hit) begin
          tok_nxt.hit = 1'b1;
          tok_nxt.rec = own;
        end
      end
      OP_FIND_INST: begin
        if (im && !tok_i.hit) begin
          tok_nxt.hit = 1'b1;
          tok_nxt.rec = own;
        end
      end
      OP_COUNT: begin
        if (tm) begin
          tok_nxt.cnt = tok_i.cnt + CNT_W'(1);
        end
      end
      OP_LIST: begin
        // hold one match back so the final one can carry last_result
        if (tm && (int'(tok_i.cnt) < MAX_RESULTS)) begin
          if (tok_i.hit) begin
            emit_o.valid = 1'b1;
            emit_o.rec   = tok_i.rec;
          end
          tok_nxt.hit = 1'b1;
          tok_nxt.rec = own;
          tok_nxt.cnt = tok_i.cnt + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (wr_i.clr) begin
        valid_r <= 1'b0;
      end else if (wr_i.en && (wr_i.idx == IDX_W'(CELL_IDX))) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    conn_r <= conn_nxt;
    if (wr_i.en && (wr_i.idx == IDX_W'(CELL_IDX))) begin
      type_r    <= wr_i.dtype;
      backend_r <= wr_i.backend;
      inst_r    <= wr_i.inst;
      conn_r    <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/device_registry_table_top.sv -----
// Device registry table top level: command port, chain of slot cells, result
// register and append/clear control. Depends on drt_pkg and drt_cell.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------------
//   input    | start, busy (out)        | in_item  (drt_pkg::in_item_t)
//   result   | out_strobe (out)         | out_item (drt_pkg::out_item_t)
//
// An item is taken when start is high and busy is low. Add, remove, find,
// count and list walk a query token down the cell chain one slot per cycle;
// the final result is registered once the token has left the last cell, and
// busy drops with it, so no new such item is taken while one is in the chain.
// Clear and the unused opcode answer in the next cycle and leave busy low.
// List results appear as the token passes matching slots, one per cycle at most.
// Results are shown for one cycle and cannot be stalled. Reset empties the table.
`default_nettype none

module device_registry_table_top #(
  parameter int TABLE_DEPTH = drt_pkg::DEF_TABLE_DEPTH,
  parameter int TYPE_BITS   = drt_pkg::DEF_TYPE_BITS
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire drt_pkg::in_item_t in_item,
  output logic               out_strobe,
  output drt_pkg::out_item_t out_item
);
  import drt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [IDX_W-1:0]     idx;
    logic [TYPE_BITS-1:0] dtype;
    logic [31:0]          backend;
    logic [3:0]           inst;
    logic                 conn;
  } rec_t;

  typedef struct packed {
    logic                 valid;
    logic [2:0]           op;
    logic [TYPE_BITS-1:0] dtype;
    logic [31:0]          backend;
    logic [3:0]           inst;
    logic                 hit;
    rec_t                 rec;
    logic [4:0]           next_inst;
    logic [CNT_W-1:0]     cnt;
  } tok_t;

  typedef struct packed {
    logic                 clr;
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic [TYPE_BITS-1:0] dtype;
    logic [31:0]          backend;
    logic [3:0]           inst;
  } wr_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } emit_t;

  tok_t             tok_c [TABLE_DEPTH+1];
  tok_t             tok_head;
  emit_t            emit_c [TABLE_DEPTH];
  emit_t            emit_any;
  tok_t             fin;
  wr_t              wr;
  rec_t             new_rec;
  logic             accept;
  logic             scan;
  logic [TYPE_BITS+3:0] type_ext;
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic             strobe_r, strobe_nxt;
  out_item_t        out_r, out_nxt;

  function automatic out_item_t rec_to_out(rec_t r);
    out_item_t            o;
    logic [IDX_W+3:0]     idx_ext;
    logic [TYPE_BITS+3:0] typ_ext;
    o                  = '0;
    idx_ext            = (IDX_W + 4)'(r.idx);
    typ_ext            = (TYPE_BITS + 4)'(r.dtype);
    o.entry_index      = idx_ext[3:0];
    o.entry_type       = typ_ext[3:0];
    o.entry_backend_id = r.backend;
    o.entry_instance   = r.inst;
    o.entry_connected  = r.conn;
    return o;
  endfunction

  assign accept   = start && !busy_r;
  assign scan     = (in_item.opcode <= OP_LIST);
  assign type_ext = (TYPE_BITS + 4)'(in_item.device_type);
  assign busy       = busy_r;
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  always_comb begin
    tok_head         = '0;
    tok_head.valid   = accept && scan;
    tok_head.op      = in_item.opcode;
    tok_head.dtype   = type_ext[TYPE_BITS-1:0];
    tok_head.backend = in_item.backend_id;
    tok_head.inst    = in_item.instance_number;
  end

  assign tok_c[0] = tok_head;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    drt_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (g),
      .tok_t    (tok_t),
      .rec_t    (rec_t),
      .wr_t     (wr_t),
      .emit_t   (emit_t)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_i  (tok_c[g]),
      .tok_o  (tok_c[g+1]),
      .wr_i   (wr),
      .emit_o (emit_c[g])
    );
  end

  // only the cell holding the token can emit, so an OR picks it out
  always_comb begin
    emit_any = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      emit_any = emit_t'(emit_any | emit_c[i]);
    end
  end

  assign fin = tok_c[TABLE_DEPTH];

  always_comb begin
    busy_nxt   = busy_r;
    used_nxt   = used_r;
    strobe_nxt = 1'b0;
    out_nxt    = '0;
    wr         = '0;
    new_rec         = '0;
    new_rec.idx     = used_r[IDX_W-1:0];
    new_rec.dtype   = fin.dtype;
    new_rec.backend = fin.backend;
    new_rec.inst    = (fin.next_inst > 5'(INST_MAX)) ? 4'(INST_MAX) : fin.next_inst[3:0];
    new_rec.conn    = 1'b1;

    if (accept) begin
      busy_nxt = scan;
      if (!scan) begin
        strobe_nxt          = 1'b1;
        out_nxt.status      = ST_OK;
        out_nxt.last_result = 1'b1;
        if (in_item.opcode == OP_CLEAR) begin
          wr.clr   = 1'b1;
          used_nxt = '0;
        end
      end
    end

    if (emit_any.valid) begin
      strobe_nxt     = 1'b1;
      out_nxt        = rec_to_out(emit_any.rec);
      out_nxt.status = ST_OK;
    end

    if (fin.valid) begin
      busy_nxt   = 1'b0;
      strobe_nxt = 1'b1;
      case (fin.op)
        OP_ADD: begin
          if (fin.hit) begin
            out_nxt = rec_to_out(fin.rec);
          end else if (used_r >= CNT_W'(TABLE_DEPTH)) begin
            out_nxt.status = ST_FULL;
          end else begin
            wr.en      = 1'b1;
            wr.idx     = new_rec.idx;
            wr.dtype   = new_rec.dtype;
            wr.backend = new_rec.backend;
            wr.inst    = new_rec.inst;
            used_nxt   = used_r + CNT_W'(1);
            out_nxt    = rec_to_out(new_rec);
          end
        end
        OP_COUNT: begin
          out_nxt.type_count = (int'(fin.cnt) > COUNT_MAX) ? 5'(COUNT_MAX) : 5'(fin.cnt);
        end
        default: begin
          // remove, find and list end the same way: report the held match
          if (fin.hit) begin
            out_nxt = rec_to_out(fin.rec);
          end else begin
            out_nxt.status = ST_NOT_FOUND;
          end
        end
      endcase
      out_nxt.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      used_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      used_r   <= used_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/drt_checker.sv -----
// Port-level checker for the device registry table, bound to the top level.
// Depends on drt_pkg and device_registry_table_top.
`default_nettype none

module drt_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                start,
  input wire                busy,
  input wire                out_strobe,
  input wire drt_pkg::out_item_t out_item
);
  import drt_pkg::*;

  // a result only follows an accepted item or comes while one is in work
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) || $past(start && !busy)))
    else $error("result without an item in work");

  // the item ends with its final result
  a_busy_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_strobe && out_item.last_result))
    else $error("busy dropped without a final result");

  // a result that is not the last one means more are coming
  a_more_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last_result) |-> busy)
    else $error("partial result after item finished");

  // failure results carry no entry
  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status != ST_OK)) |->
      (out_item.entry_index == '0 && out_item.entry_backend_id == '0 &&
       out_item.entry_connected == 1'b0 && out_item.type_count == '0))
    else $error("failure result carries entry data");

endmodule

bind device_registry_table_top drt_checker u_drt_checker (.*);

`default_nettype wire

// ----- sim/device_registry_table_top_test.sv -----
// Testbench for device_registry_table_top: directed and random command traffic,
// every result checked against a behavioral copy of the device table.
// Depends on drt_pkg and the device_registry_table_top RTL.
`timescale 1ns / 100ps

module device_registry_table_top_test;
  import drt_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int TAIL_CYCLES = 2 * (DEPTH + 1) + 6;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  cmd_item;
  logic      out_strobe;
  out_item_t reply_item;

  device_registry_table_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (cmd_item),
    .out_strobe(out_strobe),
    .out_item  (reply_item)
  );

  // shadow copy of the device table
  logic              dev_valid [DEPTH];
  logic [3:0]        dev_type  [DEPTH];
  logic signed [31:0] dev_id   [DEPTH];
  logic [3:0]        dev_inst  [DEPTH];
  logic              dev_conn  [DEPTH];
  int                dev_used;

  out_item_t expected_replies[$];

  int idle_pct;
  int mismatch_count;
  int replies_checked;
  int cmds_accepted;
  int full_replies;
  int multi_lists;
  int op_seen [8];
  logic signed [31:0] id_pool [8];
  logic [3:0] common_types [4] = '{4'h0, 4'h5, 4'hA, 4'hF};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int find_by_id(logic [3:0] ty, logic signed [31:0] id);
    for (int i = 0; i < DEPTH; i++)
      if (dev_valid[i] && dev_type[i] == ty && dev_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_by_inst(logic [3:0] ty, logic [3:0] inst);
    for (int i = 0; i < DEPTH; i++)
      if (dev_valid[i] && dev_type[i] == ty && dev_inst[i] == inst) return i;
    return -1;
  endfunction

  function automatic out_item_t entry_reply(logic [1:0] st, int slot, logic [4:0] cnt,
                                            logic last);
    out_item_t r;
    r = '0;
    r.status = st;
    if (slot >= 0) begin
      r.entry_index      = slot[3:0];
      r.entry_type       = dev_type[slot];
      r.entry_backend_id = dev_id[slot];
      r.entry_instance   = dev_inst[slot];
      r.entry_connected  = dev_conn[slot];
    end
    r.type_count  = cnt;
    r.last_result = last;
    return r;
  endfunction

  function automatic string fmt_item(out_item_t r);
    return $sformatf("st=%0d idx=%0d ty=%0d id=%h inst=%0d con=%0b cnt=%0d last=%0b",
                     r.status, r.entry_index, r.entry_type, r.entry_backend_id,
                     r.entry_instance, r.entry_connected, r.type_count, r.last_result);
  endfunction

  function automatic void add_reply(out_item_t r);
    expected_replies.insert(expected_replies.size(), r);
  endfunction

  // Updates the shadow table for one accepted command and queues its replies.
  function automatic void registry_apply(in_item_t c);
    int hit;
    int nxt;
    int cnt;
    int n;
    logic [3:0] ty;
    ty = c.device_type;
    case (c.opcode) inside
      OP_ADD: begin
        hit = find_by_id(ty, c.backend_id);
        if (hit >= 0) begin
          dev_conn[hit] = 1'b1;
          add_reply(entry_reply(ST_OK, hit, '0, 1'b1));
        end else if (dev_used >= DEPTH) begin
          add_reply(entry_reply(ST_FULL, -1, '0, 1'b1));
        end else begin
          nxt = 0;
          for (int i = 0; i < DEPTH; i++)
            if (dev_valid[i] && dev_type[i] == ty && dev_inst[i] >= nxt)
              nxt = dev_inst[i] + 1;
          if (nxt > INST_MAX) nxt = INST_MAX;
          dev_valid[dev_used] = 1'b1;
          dev_type[dev_used]  = ty;
          dev_id[dev_used]    = c.backend_id;
          dev_inst[dev_used]  = nxt[3:0];
          dev_conn[dev_used]  = 1'b1;
          add_reply(entry_reply(ST_OK, dev_used, '0, 1'b1));
          dev_used++;
        end
      end
      OP_REMOVE: begin
        hit = find_by_id(ty, c.backend_id);
        if (hit >= 0) begin
          dev_conn[hit] = 1'b0;
          add_reply(entry_reply(ST_OK, hit, '0, 1'b1));
        end else begin
          add_reply(entry_reply(ST_NOT_FOUND, -1, '0, 1'b1));
        end
      end
      OP_FIND_BE, OP_FIND_INST: begin
        hit = (c.opcode == OP_FIND_BE) ? find_by_id(ty, c.backend_id)
                                       : find_by_inst(ty, c.instance_number);
        add_reply(entry_reply((hit >= 0) ? ST_OK : ST_NOT_FOUND, hit, '0, 1'b1));
      end
      OP_COUNT: begin
        cnt = 0;
        for (int i = 0; i < DEPTH; i++)
          if (dev_valid[i] && dev_type[i] == ty) cnt++;
        if (cnt > COUNT_MAX) cnt = COUNT_MAX;
        add_reply(entry_reply(ST_OK, -1, cnt[4:0], 1'b1));
      end
      OP_LIST: begin
        n = 0;
        for (int i = 0; i < DEPTH && n < MAX_RESULTS; i++) begin
          if (dev_valid[i] && dev_type[i] == ty) begin
            add_reply(entry_reply(ST_OK, i, '0, 1'b0));
            n++;
          end
        end
        if (n == 0) add_reply(entry_reply(ST_NOT_FOUND, -1, '0, 1'b1));
        else expected_replies[$].last_result = 1'b1;
        if (n > 1) multi_lists++;
      end
      OP_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) dev_valid[i] = 1'b0;
        dev_used = 0;
        add_reply(entry_reply(ST_OK, -1, '0, 1'b1));
      end
      default: begin
        add_reply(entry_reply(ST_OK, -1, '0, 1'b1));
      end
    endcase
  endfunction

  // results are checked before the same-edge command is predicted
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t unexpected item: %s", $realtime, fmt_item(reply_item));
        end else begin
          want = expected_replies.pop_front();
          replies_checked++;
          if (want.status == ST_FULL) full_replies++;
          if (reply_item !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t mismatch exp: %s", $realtime, fmt_item(want));
              $display("%0t          got: %s", $realtime, fmt_item(reply_item));
            end
          end
        end
      end
      if (start && !busy) begin
        cmds_accepted++;
        op_seen[cmd_item.opcode]++;
        registry_apply(cmd_item);
      end
    end
  end

  function automatic in_item_t mk_cmd(logic [2:0] op, logic [3:0] ty, logic signed [31:0] id,
                                      logic [3:0] inst);
    in_item_t c;
    c.opcode          = op;
    c.device_type     = ty;
    c.backend_id      = id;
    c.instance_number = inst;
    return c;
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_item(in_item_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    cmd_item <= c;
    do @(posedge clk); while (busy);
  endtask

  // one edge first so the item taken at the calling edge is already predicted
  task automatic wait_all_replies();
    start <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_item(mk_cmd(OP_UNUSED, 4'($urandom_range(15)), $urandom, 4'($urandom_range(15))));
    send_item(mk_cmd(OP_LIST, 4'h0, 32'sd0, 4'h0));
    send_item(mk_cmd(OP_REMOVE, 4'hF, 32'sh7fffffff, 4'h0));
    send_item(mk_cmd(OP_FIND_INST, 4'h0, 32'sd0, 4'h0));
    send_item(mk_cmd(OP_COUNT, 4'hF, -32'sd1, 4'hF));
  endtask

  // sixteen devices of one type: fills the table and gives a 16-item list
  task automatic test_fill_and_long_list();
    for (int i = 0; i < DEPTH; i++) begin
      if (i < 4) id_pool[i] = (i == 0) ? 32'sh80000000 : (i == 1) ? 32'sh7fffffff :
                              (i == 2) ? 32'sd0 : -32'sd1;
      else if (i < 8) id_pool[i] = $urandom;
      send_item(mk_cmd(OP_ADD, 4'h5, (i < 8) ? id_pool[i] : $urandom, 4'h0));
    end
    send_item(mk_cmd(OP_LIST, 4'h5, 32'sd0, 4'h0));
  endtask

  task automatic test_full_table_ops();
    send_item(mk_cmd(OP_ADD, 4'hA, id_pool[1], 4'h0));
    send_item(mk_cmd(OP_REMOVE, 4'h5, id_pool[0], 4'h0));
    send_item(mk_cmd(OP_ADD, 4'h5, id_pool[0], 4'h0));
    send_item(mk_cmd(OP_FIND_BE, 4'h5, id_pool[3], 4'h0));
    send_item(mk_cmd(OP_FIND_INST, 4'h5, 32'sd15, 4'hF));
    send_item(mk_cmd(OP_COUNT, 4'h5, 32'sd0, 4'h0));
    wait_all_replies();
    send_item(mk_cmd(OP_CLEAR, 4'h0, 32'sd0, 4'h0));
  endtask

  function automatic in_item_t random_command();
    int roll;
    in_item_t c;
    roll = $urandom_range(99);
    if (roll < 35) c.opcode = OP_ADD;
    else if (roll < 47) c.opcode = OP_REMOVE;
    else if (roll < 59) c.opcode = OP_FIND_BE;
    else if (roll < 71) c.opcode = OP_FIND_INST;
    else if (roll < 79) c.opcode = OP_COUNT;
    else if (roll < 91) c.opcode = OP_LIST;
    else if (roll < 95) c.opcode = OP_CLEAR;
    else c.opcode = OP_UNUSED;
    c.device_type = ($urandom_range(99) < 65) ? common_types[$urandom_range(3)]
                                              : 4'($urandom_range(15));
    if ($urandom_range(99) < 60) begin
      c.backend_id = id_pool[$urandom_range(7)];
    end else begin
      c.backend_id = $urandom;
      if ($urandom_range(3) == 0) id_pool[$urandom_range(7)] = c.backend_id;
    end
    c.instance_number = ($urandom_range(99) < 70) ? 4'($urandom_range(4))
                                                  : 4'($urandom_range(15));
    return c;
  endfunction

  task automatic test_random_traffic(int n_items, int pct);
    idle_pct = pct;
    for (int i = 0; i < n_items; i++) send_item(random_command());
    wait_all_replies();
  endtask

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    cmd_item = '0;
    idle_pct = 19;
    dev_used = 0;
    mismatch_count  = 0;
    replies_checked = 0;
    cmds_accepted   = 0;
    full_replies    = 0;
    multi_lists     = 0;
    for (int i = 0; i < 8; i++) op_seen[i] = 0;
    for (int i = 0; i < DEPTH; i++) begin
      dev_valid[i] = 1'b0;
      dev_type[i]  = '0;
      dev_id[i]    = '0;
      dev_inst[i]  = '0;
      dev_conn[i]  = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_fill_and_long_list();
    test_full_table_ops();
    test_random_traffic(60, 19);
    test_random_traffic(60, 86);
    test_random_traffic(60, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d commands (add %0d, remove %0d, list %0d, clear %0d, unused %0d)",
             cmds_accepted, op_seen[OP_ADD], op_seen[OP_REMOVE], op_seen[OP_LIST],
             op_seen[OP_CLEAR], op_seen[OP_UNUSED]);
    $display("checked %0d result items, %0d full-table refusals, %0d multi-entry lists",
             replies_checked, full_replies, multi_lists);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/drt_pkg.sv
hdl/drt_cell.sv
hdl/device_registry_table_top.sv
hdl/drt_checker.sv
sim/device_registry_table_top_test.sv
